/* rtl/firlat_pkg.sv */
// Shared types, constants and fixed-point helpers of the lattice filter.
package firlat_pkg;

  localparam int DATA_W     = 16;
  localparam int COEF_W     = 16;
  localparam int MAX_STAGES = 8;
  localparam int COEF_IDX_W = 3;
  localparam int CFG_IDX_W  = 8;
  localparam int PROD_W     = DATA_W + COEF_W;
  localparam int RND_W      = PROD_W - 13;
  localparam int DIFF_W     = RND_W + 1;

  // Per-cycle commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;    // take a new sample into f
    logic mul_b;   // multiply k[s] by stored backward value, write back b[s]
    logic mul_f;   // multiply k[s] by f, update f
    logic emit;    // load the output register with the final residual
  } cmd_t;

  // Q3.29 product to Q1.15, half rounds toward +infinity.
  function automatic logic signed [RND_W-1:0] rnd_q15(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] sum;
    begin
      sum = {p[PROD_W-1], p} + (PROD_W+1)'(8192);
      rnd_q15 = sum[PROD_W:14];
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [DIFF_W-1:0] v);
    begin
      if (v > DIFF_W'(32767)) begin
        sat16 = 16'sh7fff;
      end else if (v < -DIFF_W'(32768)) begin
        sat16 = 16'sh8000;
      end else begin
        sat16 = v[DATA_W-1:0];
      end
    end
  endfunction

  // a - rnd(p), saturated to 16 bits.
  function automatic logic signed [DATA_W-1:0] sub_sat(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [PROD_W-1:0] p);
    logic signed [DIFF_W-1:0] d;
    begin
      d = DIFF_W'(a) - DIFF_W'(rnd_q15(p));
      sub_sat = sat16(d);
    end
  endfunction

endpackage

/* rtl/firlat_sample_if.sv */
// Input sample channel.
interface firlat_sample_if;
  logic                                        valid;
  logic                                        ready;
  logic signed [firlat_pkg::DATA_W-1:0]        sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

/* rtl/firlat_residual_if.sv */
// Output residual channel.
interface firlat_residual_if;
  logic                                        valid;
  logic                                        ready;
  logic signed [firlat_pkg::DATA_W-1:0]        residual_out;

  modport source (output valid, output residual_out, input ready);
  modport sink   (input valid, input residual_out, output ready);
endinterface

/* rtl/firlat_cfg_if.sv */
// Coefficient write channel.
interface firlat_cfg_if;
  logic                                        valid;
  logic                                        ready;
  logic [firlat_pkg::CFG_IDX_W-1:0]            index;
  logic [firlat_pkg::COEF_W-1:0]               data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/firlat_ctrl.sv */
// Sequencer: walks the stages, two multiply phases per stage, and owns the handshakes.
module firlat_ctrl #(
  parameter int ORDER = 8,
  parameter int IDX_W = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [IDX_W-1:0]   stage,
  output firlat_pkg::cmd_t   cmd
);

  typedef enum logic {IDLE, RUN} state_t;

  state_t state;
  logic   phase;
  logic   last;
  logic   slot_free;

  assign last      = (stage == IDX_W'(ORDER - 1));
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE: cmd.load = in_valid;
      RUN: begin
        if (!phase) begin
          cmd.mul_b = 1'b1;
        end else if (!last || slot_free) begin
          cmd.mul_f = 1'b1;
          cmd.emit  = last;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      phase     <= 1'b0;
      stage     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !cmd.emit) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            state <= RUN;
            phase <= 1'b0;
            stage <= '0;
          end
        end
        RUN: begin
          if (!phase) begin
            phase <= 1'b1;
          end else if (!last) begin
            phase <= 1'b0;
            stage <= stage + IDX_W'(1);
          end else if (slot_free) begin
            // stalls here while the previous result is still unclaimed
            state     <= IDLE;
            out_valid <= 1'b1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* rtl/firlat_dp.sv */
// Datapath: coefficient and backward-delay registers, shared multiplier, stage arithmetic.
module firlat_dp #(
  parameter int ORDER = 8,
  parameter int IDX_W = 3
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  firlat_pkg::cmd_t                         cmd,
  input  logic [IDX_W-1:0]                         stage,
  input  logic signed [firlat_pkg::DATA_W-1:0]     sample_in,
  input  logic                                     cfg_we,
  input  logic [firlat_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [firlat_pkg::COEF_W-1:0]            cfg_data,
  output logic signed [firlat_pkg::DATA_W-1:0]     residual_out
);

  localparam int DW = firlat_pkg::DATA_W;
  localparam int PW = firlat_pkg::PROD_W;

  logic signed [firlat_pkg::COEF_W-1:0] coef [firlat_pkg::MAX_STAGES];
  logic signed [DW-1:0]                 bdel [ORDER];
  logic signed [DW-1:0]                 f;
  logic signed [DW-1:0]                 bcur;   // old b of the current stage
  logic signed [PW-1:0]                 prod;
  logic signed [firlat_pkg::COEF_W-1:0] k;
  logic signed [DW-1:0]                 mul_a;
  logic signed [DW-1:0]                 f_next;

  assign k      = coef[firlat_pkg::COEF_IDX_W'(stage)];
  assign mul_a  = cmd.mul_b ? bdel[stage] : f;
  assign f_next = firlat_pkg::sub_sat(f, prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < firlat_pkg::MAX_STAGES; i++) begin
        coef[i] <= '0;
      end
    end else if (cfg_we && cfg_index < firlat_pkg::CFG_IDX_W'(firlat_pkg::MAX_STAGES)) begin
      coef[cfg_index[firlat_pkg::COEF_IDX_W-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ORDER; i++) begin
        bdel[i] <= '0;
      end
    end else if (cmd.mul_b) begin
      // stage 0 takes the sample itself; others take b[s-1] - k[s-1]*f[s-1]
      if (stage == '0) begin
        bdel[stage] <= f;
      end else begin
        bdel[stage] <= firlat_pkg::sub_sat(bcur, prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      f <= sample_in;
    end else if (cmd.mul_f) begin
      f <= f_next;
    end
    if (cmd.mul_b) begin
      bcur <= bdel[stage];
    end
    if (cmd.mul_b || cmd.mul_f) begin
      prod <= PW'(k) * PW'(mul_a);
    end
    if (cmd.emit) begin
      residual_out <= f_next;
    end
  end

endmodule

/* rtl/fir_lattice_filter.sv */
// All-zero lattice filter: one shared multiplier, two products per stage.
// The result is registered, with valid set, as the last stage ends its second multiply phase.
// A new sample is taken only once the previous one has passed all stages, as the multiplier is shared.
// The output register lets a new sample enter while a result waits; the last
//   stage holds if that result is still unclaimed when the next one is ready.
// Reset (rst, synchronous): coefficients and backward delays clear to zero.
module fir_lattice_filter #(
  parameter int ORDER = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  firlat_sample_if.sink            samples,
  firlat_residual_if.source        residuals,
  firlat_cfg_if.sink               cfg
);

  localparam int IDX_W = (ORDER > 1) ? $clog2(ORDER) : 1;

  firlat_pkg::cmd_t   cmd;
  logic [IDX_W-1:0]   stage;

  assign cfg.ready = 1'b1;

  firlat_ctrl #(
    .ORDER (ORDER),
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (residuals.valid),
    .out_ready (residuals.ready),
    .stage     (stage),
    .cmd       (cmd)
  );

  firlat_dp #(
    .ORDER (ORDER),
    .IDX_W (IDX_W)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stage        (stage),
    .sample_in    (samples.sample_in),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .residual_out (residuals.residual_out)
  );

endmodule
